@@ design/depth_test_blend_pixel_writer_macros.svh @@
// Assertion macros for the depth test and blend pixel writer.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef DEPTH_TEST_BLEND_PIXEL_WRITER_MACROS_SVH
`define DEPTH_TEST_BLEND_PIXEL_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DTBPW_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("dtbpw: same-cycle check failed");

`define DTBPW_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("dtbpw: next-cycle check failed");

`else

`define DTBPW_ASSERT_NOW(label, cond, prop)

`define DTBPW_ASSERT_NEXT(label, cond, prop)

`endif

`endif

@@ design/dtbpw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dtbpw_pkg;

	localparam logic [23:0] DEPTH_MAX = 24'hFFFFFF;
	localparam logic [7:0] CHAN_FULL = 8'd255;

	typedef enum logic [1:0] {
		KIND_FRAG  = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MULT  = 2'd1,
		ST_WRITE = 2'd2
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic        [23:0] frag_depth;
		logic        [7:0]  src_blue;
		logic        [7:0]  src_green;
		logic        [7:0]  src_red;
		logic        [7:0]  src_alpha;
	} in_word_t;

	typedef struct packed {
		logic        accepted;
		logic [7:0]  out_blue;
		logic [7:0]  out_green;
		logic [7:0]  out_red;
		logic [7:0]  out_alpha;
		logic [23:0] out_depth;
	} out_word_t;

	typedef struct packed {
		logic [31:0] color;
		logic [23:0] depth;
	} pix_data_t;

	// Exact floor(p / 255) for any product of two 8-bit channels.
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		t = 17'(p) + 17'(p[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

@@ design/dtbpw_pixel_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtbpw_pixel_mem #(
	parameter int DEPTH = 65536,
	parameter int AW = 16
) (
	input  wire logic                clk,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	output dtbpw_pkg::pix_data_t     rd_data,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire dtbpw_pkg::pix_data_t wr_data
);

	dtbpw_pkg::pix_data_t mem [DEPTH];
	dtbpw_pkg::pix_data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ design/dtbpw_blend.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtbpw_blend (
	input  wire logic        clk,
	input  wire logic [7:0]  alpha,
	input  wire logic [31:0] src,
	input  wire logic [31:0] dst,
	output logic      [31:0] mixed
);

	logic [15:0] src_prod_s1 [4];
	logic [15:0] dst_prod_s1 [4];
	logic [7:0]  inv_alpha;

	assign inv_alpha = dtbpw_pkg::CHAN_FULL - alpha;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			src_prod_s1[i] <= 16'(alpha) * 16'(src[i*8 +: 8]);
			dst_prod_s1[i] <= 16'(inv_alpha) * 16'(dst[i*8 +: 8]);
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mixed[i*8 +: 8] = dtbpw_pkg::div255(src_prod_s1[i])
				+ dtbpw_pkg::div255(dst_prod_s1[i]);
		end
	end

endmodule

`default_nettype wire

@@ design/depth_test_blend_pixel_writer.sv @@
// Depth-tested, alpha-blending pixel writer over a frame buffer and a depth buffer.
// Command channel: a word on item is taken at a rising edge where start is high and
// busy is low. Kinds are fragment, clear one pixel and read one pixel.
// Result channel: one word per command on result, marked by done for exactly one
// cycle. The receiver cannot hold it off.
// Configuration: cfg_we writes cfg_wdata into the clear color register; write it only
// while no command is in flight.
// Sequencing: after the accepting edge the block passes through MULT and WRITE; done is high
// in the same cycle in which busy drops again. busy stays high through MULT and WRITE, so
// a new command is taken only once the previous one has finished.
// The sequence follows the read-modify-write of the pixel memory: the synchronous read,
// then the channel products, then the blend and write back.
// Color and depth share one synchronous memory of FRAME_WIDTH x FRAME_HEIGHT entries
// with no reset; a pixel must be cleared or written before it is tested or read.
// Reset clears the state machine, the done strobe and the clear color register.
`timescale 1ns / 1ps
`default_nettype none
`include "depth_test_blend_pixel_writer_macros.svh"

module depth_test_blend_pixel_writer #(
	parameter int FRAME_WIDTH = 256,
	parameter int FRAME_HEIGHT = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire dtbpw_pkg::in_word_t item,
	output logic                    done,
	output dtbpw_pkg::out_word_t    result,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_wdata
);

	localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	dtbpw_pkg::state_t    state_q, state_d;
	dtbpw_pkg::in_word_t  item_q;
	dtbpw_pkg::pix_data_t rd_data, wr_data, dst_s2;
	dtbpw_pkg::out_word_t result_d, result_q;
	logic [31:0]          clear_color_q;
	logic [AW-1:0]        addr_d, addr_q;
	logic                 in_range_d, in_range_q;
	logic                 pass_s2, done_q, accept, wr_en, x_ok, y_ok;
	logic [21:0]          lin_addr;
	logic [31:0]          src_color, mixed;

	assign accept = start && !busy;

	assign x_ok = !item.pos_x[11] && (12'(item.pos_x[10:0]) < 12'(FRAME_WIDTH));
	assign y_ok = !item.pos_y[11] && (12'(item.pos_y[10:0]) < 12'(FRAME_HEIGHT));
	assign in_range_d = x_ok && y_ok && (item.kind != dtbpw_pkg::KIND_NONE);
	assign lin_addr = 22'(item.pos_x[10:0]) + 22'(item.pos_y[10:0]) * 22'(FRAME_WIDTH);
	assign addr_d = lin_addr[AW-1:0];

	dtbpw_pixel_mem #(
		.DEPTH(PIXELS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(addr_d),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(addr_q),
		.wr_data(wr_data)
	);

	assign src_color = {item_q.src_alpha, item_q.src_red, item_q.src_green, item_q.src_blue};

	dtbpw_blend u_blend (
		.clk(clk),
		.alpha(item_q.src_alpha),
		.src(src_color),
		.dst(rd_data.color),
		.mixed(mixed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_color_q <= 32'd0;
		end else if (cfg_we) begin
			clear_color_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtbpw_pkg::ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == dtbpw_pkg::ST_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			addr_q <= addr_d;
			in_range_q <= in_range_d;
		end
		if (state_q == dtbpw_pkg::ST_MULT) begin
			dst_s2 <= rd_data;
			pass_s2 <= item_q.frag_depth <= rd_data.depth;
		end
		if (state_q == dtbpw_pkg::ST_WRITE) begin
			result_q <= result_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		case (state_q)
			dtbpw_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = dtbpw_pkg::ST_MULT;
				end
			end
			dtbpw_pkg::ST_MULT: begin
				state_d = dtbpw_pkg::ST_WRITE;
			end
			dtbpw_pkg::ST_WRITE: begin
				state_d = dtbpw_pkg::ST_IDLE;
			end
			default: begin
				state_d = dtbpw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_data.color = mixed;
		wr_data.depth = item_q.frag_depth;
		result_d = '0;
		if (in_range_q) begin
			case (item_q.kind)
				dtbpw_pkg::KIND_FRAG: begin
					if (pass_s2) begin
						wr_en = 1'b1;
						result_d.accepted = 1'b1;
						result_d.out_alpha = mixed[31:24];
						result_d.out_red = mixed[23:16];
						result_d.out_green = mixed[15:8];
						result_d.out_blue = mixed[7:0];
						result_d.out_depth = item_q.frag_depth;
					end else begin
						result_d.out_alpha = dst_s2.color[31:24];
						result_d.out_red = dst_s2.color[23:16];
						result_d.out_green = dst_s2.color[15:8];
						result_d.out_blue = dst_s2.color[7:0];
						result_d.out_depth = dst_s2.depth;
					end
				end
				dtbpw_pkg::KIND_CLEAR: begin
					wr_en = 1'b1;
					wr_data.color = clear_color_q;
					wr_data.depth = dtbpw_pkg::DEPTH_MAX;
					result_d.accepted = 1'b1;
					result_d.out_alpha = clear_color_q[31:24];
					result_d.out_red = clear_color_q[23:16];
					result_d.out_green = clear_color_q[15:8];
					result_d.out_blue = clear_color_q[7:0];
					result_d.out_depth = dtbpw_pkg::DEPTH_MAX;
				end
				dtbpw_pkg::KIND_READ: begin
					result_d.accepted = 1'b1;
					result_d.out_alpha = dst_s2.color[31:24];
					result_d.out_red = dst_s2.color[23:16];
					result_d.out_green = dst_s2.color[15:8];
					result_d.out_blue = dst_s2.color[7:0];
					result_d.out_depth = dst_s2.depth;
				end
				default: begin
					result_d = '0;
				end
			endcase
		end
		if (state_q != dtbpw_pkg::ST_WRITE) begin
			wr_en = 1'b0;
		end
	end

	assign done = done_q;
	assign result = result_q;

	`DTBPW_ASSERT_NEXT(a_accept_busy, accept, busy && !done)
	`DTBPW_ASSERT_NEXT(a_write_done, state_q == dtbpw_pkg::ST_WRITE, done && !busy)
	`DTBPW_ASSERT_NOW(a_write_in_slot, wr_en, state_q == dtbpw_pkg::ST_WRITE && in_range_q)
	`DTBPW_ASSERT_NOW(a_done_idle, done, !busy)

endmodule

`default_nettype wire
